// ===== design/assert_macros.svh =====
// Assertion helpers used by periodic_task_timer_table.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is silent while reset is held.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/ptt_pkg.sv =====
`default_nettype none
package ptt_pkg;
    localparam int NUM_TASKS = 16;
    localparam int CNT_W = $clog2(NUM_TASKS + 1);
    localparam int MAX_RES = 16;
    localparam int RES_W = 5;

    localparam logic [3:0] CMD_TICK   = 4'd0;
    localparam logic [3:0] CMD_POLL   = 4'd1;
    localparam logic [3:0] CMD_SUB    = 4'd2;
    localparam logic [3:0] CMD_UNSUB  = 4'd3;
    localparam logic [3:0] CMD_SETP   = 4'd4;
    localparam logic [3:0] CMD_SETS   = 4'd5;
    localparam logic [3:0] CMD_SETT   = 4'd6;
    localparam logic [3:0] CMD_SETPRI = 4'd7;
    localparam logic [3:0] CMD_TRIG   = 4'd8;
    localparam logic [3:0] CMD_QUERY  = 4'd9;

    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_STOPPED = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic [1:0] TY_PERIODIC = 2'd0;
    localparam logic [1:0] TY_TRIGGER  = 2'd1;
    localparam logic [1:0] TY_ONCE     = 2'd2;
    localparam logic [1:0] TY_UNKNOWN  = 2'd3;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_NOTFOUND = 3'd1;
    localparam logic [2:0] STAT_INVALID  = 3'd2;
    localparam logic [2:0] STAT_FULL     = 3'd3;
    localparam logic [2:0] STAT_NONE     = 3'd4;

    localparam logic [1:0] KIND_FIRE  = 2'd0;
    localparam logic [1:0] KIND_IDLE  = 2'd1;
    localparam logic [1:0] KIND_REPLY = 2'd2;

    typedef struct packed {
        logic [7:0]  id;
        logic [1:0]  state;
        logic [1:0]  ttype;
        logic        prio;
        logic [15:0] period;
        logic [15:0] count;
    } slot_t;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [7:0]  id;
        logic [15:0] per;
        logic [1:0]  code;
        logic        op_ok;
        logic        nopend;
        logic        adv;
        logic        prio;
    } job_t;

    typedef struct packed {
        logic        hit;
        logic        fire;
        logic [2:0]  status;
        logic [15:0] qper;
        logic [1:0]  qstate;
        logic [1:0]  qtype;
    } head_res_t;
endpackage
`default_nettype wire

// ===== design/ptt_cell.sv =====
`default_nettype none
module ptt_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          shift,
    input  wire ptt_pkg::slot_t d,
    output ptt_pkg::slot_t     q
);
    ptt_pkg::slot_t slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else if (shift) begin
            slot_reg <= d;
        end
    end

    assign q = slot_reg;
endmodule
`default_nettype wire

// ===== design/ptt_head.sv =====
`default_nettype none
module ptt_head (
    input  wire ptt_pkg::slot_t slot_i,
    input  wire ptt_pkg::job_t  job,
    input  wire logic [9:0]     base_time,
    input  wire logic           found,
    output ptt_pkg::slot_t      slot_o,
    output ptt_pkg::head_res_t  res
);
    logic [16:0] sum;

    always_comb begin
        slot_o = slot_i;
        res = '0;
        sum = {1'b0, slot_i.count} + {7'b0, base_time};
        if (job.adv) begin
            if (slot_i.state == ptt_pkg::ST_RUNNING && slot_i.prio == job.prio) begin
                if (sum >= {1'b0, slot_i.period}) begin
                    res.fire = 1'b1;
                    slot_o.count = '0;
                    if (slot_i.ttype == ptt_pkg::TY_TRIGGER) begin
                        slot_o.state = ptt_pkg::ST_STOPPED;
                    end
                    if (slot_i.ttype == ptt_pkg::TY_ONCE) begin
                        slot_o = '0;
                    end
                end else begin
                    slot_o.count = sum[15:0];
                end
            end
        end else if (job.op_ok && !found) begin
            if (job.cmd == ptt_pkg::CMD_SUB) begin
                if (slot_i.state == ptt_pkg::ST_EMPTY) begin
                    slot_o = '0;
                    slot_o.id = job.id;
                    slot_o.state = ptt_pkg::ST_STOPPED;
                    res.hit = 1'b1;
                end
            end else if (slot_i.state != ptt_pkg::ST_EMPTY && slot_i.id == job.id) begin
                res.hit = 1'b1;
                case (job.cmd)
                    ptt_pkg::CMD_UNSUB: begin
                        slot_o = '0;
                    end
                    ptt_pkg::CMD_SETP: begin
                        slot_o.period = job.per;
                        slot_o.count = '0;
                    end
                    ptt_pkg::CMD_SETS: begin
                        if (job.code == ptt_pkg::ST_STOPPED || job.code == ptt_pkg::ST_RUNNING)
                        begin
                            slot_o.state = job.code;
                        end else begin
                            res.status = ptt_pkg::STAT_INVALID;
                        end
                    end
                    ptt_pkg::CMD_SETT: begin
                        if (job.code != ptt_pkg::TY_UNKNOWN) begin
                            slot_o.ttype = job.code;
                        end else begin
                            res.status = ptt_pkg::STAT_INVALID;
                        end
                    end
                    ptt_pkg::CMD_SETPRI: begin
                        if (!job.code[1]) begin
                            slot_o.prio = job.code[0];
                        end else begin
                            res.status = ptt_pkg::STAT_INVALID;
                        end
                    end
                    ptt_pkg::CMD_TRIG: begin
                        if (slot_i.ttype == ptt_pkg::TY_TRIGGER) begin
                            slot_o.count = '0;
                            slot_o.state = ptt_pkg::ST_RUNNING;
                        end else begin
                            res.status = ptt_pkg::STAT_INVALID;
                        end
                    end
                    default: begin
                        res.qper = slot_i.period;
                        res.qstate = slot_i.state;
                        res.qtype = slot_i.ttype;
                    end
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/periodic_task_timer_table.sv =====
// Every transaction walks the ring of NUM_TASKS slot cells once, one slot per cycle,
// except while a fire result waits on a stalled output. An item passes through accept,
// walk and final result, and the next item is accepted only once the final result
// has been loaded into the output register.
// Synchronous active-low reset empties every slot, clears pending ticks and
// sets base_time to 1.
`default_nettype none
`include "assert_macros.svh"
module periodic_task_timer_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // task_id[7:0], period_in[23:8], code_in[25:24]
    input  wire logic [3:0]  s_tuser,  // cmd[3:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // fired_id, status, period_out, state_out, type_out
    output logic [1:0]       m_tuser,  // kind[1:0]
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [9:0]  cfg_data
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } fsm_t;

    localparam int N = ptt_pkg::NUM_TASKS;

    fsm_t                     state_reg;
    logic [9:0]               base_reg;
    logic [7:0]               pend_reg;
    ptt_pkg::job_t            job_reg;
    logic [ptt_pkg::CNT_W-1:0] cnt_reg;
    logic                     found_reg;
    logic [2:0]               fst_reg;
    logic [15:0]              qper_reg;
    logic [1:0]               qst_reg;
    logic [1:0]               qty_reg;
    logic                     held_v_reg;
    logic [7:0]               held_id_reg;
    logic [ptt_pkg::RES_W-1:0] rep_reg;
    logic                     m_valid_reg;
    logic [31:0]              m_data_reg;
    logic [1:0]               m_user_reg;
    logic                     m_last_reg;

    ptt_pkg::slot_t    ring [N];
    ptt_pkg::slot_t    head_next;
    ptt_pkg::head_res_t hres;
    logic              s_acc, out_free, fire_rep, step, load;
    logic [31:0]       ld_data;
    logic [1:0]        ld_user;
    logic              ld_last;
    logic [3:0]        in_cmd;
    logic [7:0]        in_id;
    logic [15:0]       in_per;

    assign in_cmd = s_tuser;
    assign in_id = s_tdata[7:0];
    assign in_per = s_tdata[23:8];
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free = !m_valid_reg || m_tready;

    ptt_head u_head (
        .slot_i(ring[0]), .job(job_reg), .base_time(base_reg), .found(found_reg),
        .slot_o(head_next), .res(hres)
    );

    for (genvar i = 0; i < N; i++) begin : g_cell
        ptt_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .shift(step),
            .d((i == N - 1) ? head_next : ring[(i + 1) % N]), .q(ring[i])
        );
    end

    assign fire_rep = hres.fire && (rep_reg < ptt_pkg::RES_W'(ptt_pkg::MAX_RES));
    assign step = (state_reg == S_RUN) && !(fire_rep && held_v_reg && !out_free);

    // Result staging: a fire is held back until the next fire or the end of the walk
    // shows whether it is the final result.
    always_comb begin
        load = 1'b0;
        ld_data = '0;
        ld_user = ptt_pkg::KIND_REPLY;
        ld_last = 1'b0;
        if (step && fire_rep && held_v_reg) begin
            load = 1'b1;
            ld_user = ptt_pkg::KIND_FIRE;
            ld_data[7:0] = held_id_reg;
        end else if (state_reg == S_DONE && out_free) begin
            load = 1'b1;
            ld_last = 1'b1;
            if (job_reg.adv) begin
                if (held_v_reg) begin
                    ld_user = ptt_pkg::KIND_FIRE;
                    ld_data[7:0] = held_id_reg;
                end else begin
                    ld_user = ptt_pkg::KIND_IDLE;
                end
            end else if (job_reg.nopend) begin
                ld_data[10:8] = ptt_pkg::STAT_NONE;
            end else if (!job_reg.op_ok) begin
                ld_data[10:8] = ptt_pkg::STAT_INVALID;
                if (job_reg.cmd == ptt_pkg::CMD_QUERY) begin
                    ld_data[28:27] = ptt_pkg::ST_UNKNOWN;
                    ld_data[30:29] = ptt_pkg::TY_UNKNOWN;
                end
            end else if (found_reg) begin
                ld_data[10:8] = fst_reg;
                ld_data[26:11] = qper_reg;
                ld_data[28:27] = qst_reg;
                ld_data[30:29] = qty_reg;
            end else if (job_reg.cmd == ptt_pkg::CMD_SUB) begin
                ld_data[10:8] = ptt_pkg::STAT_FULL;
            end else begin
                ld_data[10:8] = ptt_pkg::STAT_NOTFOUND;
                if (job_reg.cmd == ptt_pkg::CMD_QUERY) begin
                    ld_data[28:27] = ptt_pkg::ST_UNKNOWN;
                    ld_data[30:29] = ptt_pkg::TY_UNKNOWN;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            base_reg <= 10'd1;
            pend_reg <= '0;
            job_reg <= '0;
            cnt_reg <= '0;
            found_reg <= 1'b0;
            held_v_reg <= 1'b0;
            rep_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                base_reg <= cfg_data;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        job_reg.cmd <= in_cmd;
                        job_reg.id <= in_id;
                        job_reg.per <= in_per;
                        job_reg.code <= s_tdata[25:24];
                        job_reg.op_ok <= (in_cmd >= ptt_pkg::CMD_SUB)
                            && (in_cmd <= ptt_pkg::CMD_QUERY) && (in_id != 8'd0)
                            && !(in_cmd == ptt_pkg::CMD_SETP && in_per < {6'b0, base_reg});
                        job_reg.prio <= (in_cmd == ptt_pkg::CMD_TICK);
                        job_reg.adv <= (in_cmd == ptt_pkg::CMD_TICK)
                            || (in_cmd == ptt_pkg::CMD_POLL && pend_reg != 8'd0);
                        job_reg.nopend <= (in_cmd == ptt_pkg::CMD_POLL && pend_reg == 8'd0);
                        if (in_cmd == ptt_pkg::CMD_TICK && pend_reg != 8'hFF) begin
                            pend_reg <= pend_reg + 8'd1;
                        end
                        if (in_cmd == ptt_pkg::CMD_POLL && pend_reg != 8'd0) begin
                            pend_reg <= pend_reg - 8'd1;
                        end
                        cnt_reg <= '0;
                        found_reg <= 1'b0;
                        held_v_reg <= 1'b0;
                        rep_reg <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (step) begin
                        if (hres.hit) begin
                            found_reg <= 1'b1;
                        end
                        if (fire_rep) begin
                            held_v_reg <= 1'b1;
                            rep_reg <= rep_reg + ptt_pkg::RES_W'(1);
                        end
                        cnt_reg <= cnt_reg + ptt_pkg::CNT_W'(1);
                        if (cnt_reg == ptt_pkg::CNT_W'(N - 1)) begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (step && hres.hit) begin
            fst_reg <= hres.status;
            qper_reg <= hres.qper;
            qst_reg <= hres.qstate;
            qty_reg <= hres.qtype;
        end
        if (step && fire_rep) begin
            held_id_reg <= ring[0].id;
        end
        if (load) begin
            m_data_reg <= ld_data;
            m_user_reg <= ld_user;
            m_last_reg <= ld_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tuser = m_user_reg;
    assign m_tlast = m_last_reg;

    `ASSERT_CLK(a_rep_limit, aclk, aresetn,
        rep_reg <= ptt_pkg::RES_W'(ptt_pkg::MAX_RES), "too many fire results reported")
    `ASSERT_CLK(a_accept_run, aclk, aresetn, s_acc |=> state_reg == S_RUN,
        "accepted transaction did not start a walk")
    `ASSERT_CLK(a_out_source, aclk, aresetn, $rose(m_tvalid) |-> $past(state_reg != S_IDLE),
        "result appeared while idle")
    `ASSERT_CLK(a_pend_sat, aclk, aresetn,
        (s_acc && in_cmd == ptt_pkg::CMD_TICK && pend_reg == 8'hFF) |=> pend_reg == 8'hFF,
        "pending tick count wrapped")
endmodule
`default_nettype wire
